/* design/pl0_pkg.sv */
// shared types, constants and codes of the pl/0 stack machine core
// no dependencies

package pl0_pkg;

  localparam int DATA_W    = 32;
  localparam int MEM_DEPTH = 512;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int SP_W      = 10;
  localparam int EXT_W     = DATA_W + 2;
  localparam int DIV_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int IN_W      = 80;
  localparam int OUT_W     = 72;

  localparam logic [ADDR_W-1:0] START_PC_RST  = ADDR_W'(10);
  localparam logic [SP_W-1:0]   STACK_TOP_RST = SP_W'(500);
  localparam logic [ADDR_W-1:0] BP_RST        = ADDR_W'(499);

  // result item bit positions
  localparam int O_HALT  = 28;
  localparam int O_OUTV  = 29;
  localparam int O_VAL_L = 30;
  localparam int O_VAL_H = 61;
  localparam int O_INP   = 62;
  localparam int O_ERR_L = 63;
  localparam int O_ERR_H = 64;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [EXT_W-1:0]  ext_t;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic CFG_START_PC  = 1'b0;
  localparam logic CFG_STACK_TOP = 1'b1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIVZ = 2'd1;
  localparam logic [1:0] ERR_ADDR = 2'd2;

  localparam word_t OP_LIT = 32'sd1;
  localparam word_t OP_OPR = 32'sd2;
  localparam word_t OP_LOD = 32'sd3;
  localparam word_t OP_STO = 32'sd4;
  localparam word_t OP_CAL = 32'sd5;
  localparam word_t OP_INC = 32'sd6;
  localparam word_t OP_JMP = 32'sd7;
  localparam word_t OP_JPC = 32'sd8;
  localparam word_t OP_SYS = 32'sd9;

  localparam word_t OPR_RTN = 32'sd0;
  localparam word_t OPR_ADD = 32'sd1;
  localparam word_t OPR_SUB = 32'sd2;
  localparam word_t OPR_MUL = 32'sd3;
  localparam word_t OPR_DIV = 32'sd4;
  localparam word_t OPR_EQL = 32'sd5;
  localparam word_t OPR_NEQ = 32'sd6;
  localparam word_t OPR_LSS = 32'sd7;
  localparam word_t OPR_LEQ = 32'sd8;
  localparam word_t OPR_GTR = 32'sd9;
  localparam word_t OPR_GEQ = 32'sd10;

  localparam word_t SYS_WRITE = 32'sd1;
  localparam word_t SYS_READ  = 32'sd2;
  localparam word_t SYS_HALT  = 32'sd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_F0, ST_F1, ST_F2, ST_F3, ST_DEC,
    ST_RT1, ST_RT2, ST_O1, ST_O2, ST_EX, ST_DIVW,
    ST_J1, ST_S1, ST_WALK, ST_WALK_C, ST_CYC, ST_CYC_C, ST_MODW,
    ST_AW, ST_L1, ST_T1, ST_FIN, ST_COMMIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic sgn;
  } div_req_t;

  function automatic ext_t sx(word_t w);
    return {{(EXT_W-DATA_W){w[DATA_W-1]}}, w};
  endfunction

  function automatic logic word_in_mem(word_t w);
    return (w >= 0) && (w < MEM_DEPTH);
  endfunction

  function automatic logic ext_in_mem(ext_t e);
    return (e >= 0) && (e < ext_t'(MEM_DEPTH));
  endfunction

endpackage

/* design/pl0_stack_machine_core_unit.sv */
// pl/0 stack machine core: sequencer, registers, word memory and shared divider
// depends on pl0_pkg, pl0_ram, pl0_div
//
// channel  | dir | handshake          | contents
// s_*      | in  | s_tvalid/s_tready  | tuser func, tdata addr, data, in_value
// m_*      | out | m_tvalid/m_tready  | tdata pc, bp, sp, halted, out_valid, ...
// cfg_*    | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// an item is taken only when idle, once the last one is done; a load item or
// a step on a stopped machine goes from accept straight to the done state, a
// step whose fetch is out of range to the finish state, and any other step
// fetches, decodes, walks links, reads or divides, then finishes. all memory
// reads go through the one read port of the word memory. a walk that loops is
// cut after 512 levels: it measures the cycle and the divider reduces the rest.
// reset (synchronous) loads pc 10, sp 500, bp 499; memory is not cleared.
// a result that waits on m_tready holds the block in its done state.

module pl0_stack_machine_core_unit import pl0_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // addr[8:0], data[40:9], in_value[72:41]
  input  logic              s_tuser,   // func
  output logic              m_tvalid,
  input  logic              m_tready,
  // pc[8:0], bp[17:9], sp[27:18], halted[28], out_valid[29],
  // out_value[61:30], input_taken[62], error[64:63]
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SP_W-1:0]   cfg_data
);

  state_t state, state_next;

  // architectural registers
  logic [ADDR_W-1:0] pc, bp;
  logic [SP_W-1:0]   sp;
  logic              stopped;

  // per-item working registers
  word_t             op_w, lv_w, m_w, x_w, y_w, cur, in_val, out_val;
  logic [DATA_W-1:0] left;
  logic [SP_W-1:0]   steps, cyc_len;
  logic [ADDR_W-1:0] anchor, cyc_node, sto_addr;
  ext_t              npc, nbp, nsp;
  logic              fault, halt, outv, inp;
  logic [1:0]        err;
  logic [1:0]        wcnt, widx;
  logic [ADDR_W-1:0] waddr [3];
  word_t             wval [3];

  // memory and divider hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  word_t             ram_wdata, ram_rdata;
  div_req_t          div_req;
  word_t             div_a, div_b, div_q, div_r;
  logic              div_done;

  logic              s_acc, m_free;
  logic [ADDR_W-1:0] f_addr;
  word_t             f_data, f_in;
  logic [SP_W-1:0]   sp_m1, sp_p1;
  logic [ADDR_W-1:0] bp_m1, bp_m2;
  logic              sp_ge1, sp_ge3, sp_le511, sp_le510, bp_ge2;
  logic              fetch_ok, cur_ok, a_ok, rd_ok;
  logic              dec_fault, aw_fault, range_bad, trig, closed;
  ext_t              mem_a, pc_e;
  word_t             alu_r;
  logic [SP_W-1:0]   cfg_top;

  assign f_addr = s_tdata[ADDR_W-1:0];
  assign f_data = s_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign f_in   = s_tdata[ADDR_W+2*DATA_W-1:ADDR_W+DATA_W];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign m_free    = !m_tvalid || m_tready;

  assign sp_m1    = sp - SP_W'(1);
  assign sp_p1    = sp + SP_W'(1);
  assign bp_m1    = bp - ADDR_W'(1);
  assign bp_m2    = bp - ADDR_W'(2);
  assign sp_ge1   = (sp != '0);
  assign sp_ge3   = (sp >= SP_W'(3));
  assign sp_le511 = (sp < SP_W'(MEM_DEPTH));
  assign sp_le510 = (sp < SP_W'(MEM_DEPTH - 1));
  assign bp_ge2   = (bp >= ADDR_W'(2));
  assign pc_e     = ext_t'(pc);
  assign fetch_ok = (pc_e + ext_t'(2)) < ext_t'(MEM_DEPTH);
  assign cur_ok   = word_in_mem(cur);
  assign rd_ok    = word_in_mem(ram_rdata);
  assign mem_a    = sx(cur) - sx(m_w);
  assign a_ok     = ext_in_mem(mem_a);

  // stack top written through config saturates to 1..512
  always_comb begin
    cfg_top = cfg_data;
    if (cfg_data == '0) begin
      cfg_top = SP_W'(1);
    end else if (cfg_data > SP_W'(MEM_DEPTH)) begin
      cfg_top = SP_W'(MEM_DEPTH);
    end
  end

  // operand checks for the decoded instruction
  always_comb begin
    dec_fault = 1'b0;
    case (op_w)
      OP_LIT: dec_fault = !sp_ge1;
      OP_OPR: begin
        if (m_w == OPR_RTN) begin
          dec_fault = !bp_ge2;
        end else if (m_w >= OPR_ADD && m_w <= OPR_GEQ) begin
          dec_fault = !sp_le510;
        end
      end
      OP_JPC: dec_fault = !sp_le511;
      OP_SYS: begin
        if (m_w == SYS_WRITE) begin
          dec_fault = !sp_le511;
        end else if (m_w == SYS_READ) begin
          dec_fault = !sp_ge1;
        end
      end
      default: dec_fault = 1'b0;
    endcase
  end

  // checks once the static link is known
  always_comb begin
    case (op_w)
      OP_LOD:  aw_fault = !a_ok || !sp_ge1;
      OP_STO:  aw_fault = !a_ok || !sp_le511;
      OP_CAL:  aw_fault = !sp_ge3;
      default: aw_fault = 1'b0;
    endcase
  end

  assign range_bad = !ext_in_mem(npc) || !ext_in_mem(nbp) ||
                     (nsp < 0) || (nsp > ext_t'(MEM_DEPTH));

  // after 512 levels the walk sits on a cycle: measure it
  assign trig   = (steps == SP_W'(MEM_DEPTH - 1)) && (left != DATA_W'(1)) && rd_ok;
  assign closed = (ram_rdata == word_t'(anchor)) || (cyc_len == SP_W'(MEM_DEPTH - 1));

  // compare and arithmetic, all but divide
  always_comb begin
    case (m_w)
      OPR_ADD: alu_r = x_w + y_w;
      OPR_SUB: alu_r = x_w - y_w;
      OPR_MUL: alu_r = x_w * y_w;
      OPR_EQL: alu_r = word_t'(x_w == y_w);
      OPR_NEQ: alu_r = word_t'(x_w != y_w);
      OPR_LSS: alu_r = word_t'(x_w < y_w);
      OPR_LEQ: alu_r = word_t'(x_w <= y_w);
      OPR_GTR: alu_r = word_t'(x_w > y_w);
      default: alu_r = word_t'(x_w >= y_w);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_tuser == FUNC_LOAD || stopped) begin
            state_next = ST_DONE;
          end else if (!fetch_ok) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_F0;
          end
        end
      end
      ST_F0: state_next = ST_F1;
      ST_F1: state_next = ST_F2;
      ST_F2: state_next = ST_F3;
      ST_F3: state_next = ST_DEC;
      ST_DEC: begin
        state_next = ST_FIN;
        if (!dec_fault) begin
          case (op_w)
            OP_OPR: begin
              if (m_w == OPR_RTN) begin
                state_next = ST_RT1;
              end else if (m_w >= OPR_ADD && m_w <= OPR_GEQ) begin
                state_next = ST_O1;
              end
            end
            OP_LOD, OP_STO, OP_CAL: state_next = ST_WALK;
            OP_JPC: state_next = ST_J1;
            OP_SYS: begin
              if (m_w == SYS_WRITE) begin
                state_next = ST_S1;
              end
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_RT1: state_next = ST_RT2;
      ST_RT2: state_next = ST_FIN;
      ST_O1:  state_next = ST_O2;
      ST_O2:  state_next = ST_EX;
      ST_EX: begin
        if (m_w == OPR_DIV && y_w != 0) begin
          state_next = ST_DIVW;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_J1: state_next = ST_FIN;
      ST_S1: state_next = ST_FIN;
      ST_WALK: begin
        if (left == '0) begin
          state_next = ST_AW;
        end else if (!cur_ok) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_WALK_C;
        end
      end
      ST_WALK_C: state_next = trig ? ST_CYC : ST_WALK;
      ST_CYC:    state_next = ST_CYC_C;
      ST_CYC_C:  state_next = closed ? ST_MODW : ST_CYC;
      ST_MODW: begin
        if (div_done) begin
          state_next = ST_WALK;
        end
      end
      ST_AW: begin
        state_next = ST_FIN;
        if (!aw_fault) begin
          if (op_w == OP_LOD) begin
            state_next = ST_L1;
          end else if (op_w == OP_STO) begin
            state_next = ST_T1;
          end
        end
      end
      ST_L1: state_next = ST_FIN;
      ST_T1: state_next = ST_FIN;
      ST_FIN: state_next = (fault || range_bad) ? ST_DONE : ST_COMMIT;
      ST_COMMIT: begin
        if (widx == wcnt) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (m_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory ports and divider requests
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr[widx[1:0] == 2'd3 ? 2'd0 : widx];
    ram_wdata = wval[widx[1:0] == 2'd3 ? 2'd0 : widx];
    ram_raddr = '0;
    div_req   = '{start: 1'b0, sgn: 1'b1};
    div_a     = x_w;
    div_b     = y_w;
    case (state)
      ST_IDLE: begin
        ram_we    = s_acc && (s_tuser == FUNC_LOAD);
        ram_waddr = f_addr;
        ram_wdata = f_data;
      end
      ST_F0: ram_raddr = pc;
      ST_F1: ram_raddr = pc + ADDR_W'(1);
      ST_F2: ram_raddr = pc + ADDR_W'(2);
      ST_DEC: begin
        if (op_w == OP_OPR && m_w == OPR_RTN) begin
          ram_raddr = bp_m1;
        end else begin
          ram_raddr = sp[ADDR_W-1:0];
        end
      end
      ST_O1:   ram_raddr = sp_p1[ADDR_W-1:0];
      ST_RT1:  ram_raddr = bp_m2;
      ST_EX:   div_req.start = (m_w == OPR_DIV) && (y_w != 0);
      ST_WALK: ram_raddr = cur[ADDR_W-1:0];
      ST_CYC:  ram_raddr = cyc_node;
      ST_CYC_C: begin
        div_req = '{start: closed, sgn: 1'b0};
        div_a   = word_t'(left);
        div_b   = word_t'(cyc_len + SP_W'(1));
      end
      ST_AW: begin
        if (op_w == OP_LOD) begin
          ram_raddr = mem_a[ADDR_W-1:0];
        end else begin
          ram_raddr = sp[ADDR_W-1:0];
        end
      end
      ST_COMMIT: ram_we = (widx != wcnt);
      default: ram_we = 1'b0;
    endcase
  end

  // architectural registers, config writes and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= START_PC_RST;
      sp       <= STACK_TOP_RST;
      bp       <= BP_RST;
      stopped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START_PC) begin
          pc <= cfg_data[ADDR_W-1:0];
        end else begin
          sp <= cfg_top;
          bp <= ADDR_W'(cfg_top - SP_W'(1));
        end
      end
      if (state == ST_FIN) begin
        if (fault || range_bad) begin
          stopped <= 1'b1;
        end else begin
          pc <= npc[ADDR_W-1:0];
          bp <= nbp[ADDR_W-1:0];
          sp <= nsp[SP_W-1:0];
          if (halt) begin
            stopped <= 1'b1;
          end
        end
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_DONE && m_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && m_free) begin
      m_tdata <= {7'b0, err, inp, out_val, outv, stopped, sp, bp, pc};
    end
  end

  // working registers of one item
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        in_val  <= f_in;
        outv    <= 1'b0;
        inp     <= 1'b0;
        halt    <= 1'b0;
        err     <= ERR_NONE;
        out_val <= '0;
        wcnt    <= '0;
        widx    <= '0;
        fault   <= (s_tuser == FUNC_STEP) && !fetch_ok;
      end
      ST_F1: op_w <= ram_rdata;
      ST_F2: lv_w <= ram_rdata;
      ST_F3: begin
        m_w <= ram_rdata;
        npc <= pc_e + ext_t'(3);
        nbp <= ext_t'(bp);
        nsp <= ext_t'(sp);
      end
      ST_DEC: begin
        if (dec_fault) begin
          fault <= 1'b1;
        end else begin
          case (op_w)
            OP_LIT: begin
              waddr[0] <= sp_m1[ADDR_W-1:0];
              wval[0]  <= m_w;
              wcnt     <= 2'd1;
              nsp      <= ext_t'(sp_m1);
            end
            OP_OPR: begin
              if (m_w == OPR_RTN) begin
                nsp <= ext_t'(bp) + ext_t'(1);
              end
            end
            OP_LOD, OP_STO, OP_CAL: begin
              cur   <= word_t'(bp);
              left  <= lv_w[DATA_W-1] ? '0 : DATA_W'(lv_w);
              steps <= '0;
            end
            OP_INC: nsp <= ext_t'(sp) - sx(m_w);
            OP_JMP: npc <= sx(m_w);
            OP_SYS: begin
              if (m_w == SYS_READ) begin
                waddr[0] <= sp_m1[ADDR_W-1:0];
                wval[0]  <= in_val;
                wcnt     <= 2'd1;
                nsp      <= ext_t'(sp_m1);
                inp      <= 1'b1;
              end else if (m_w == SYS_HALT) begin
                halt <= 1'b1;
              end
            end
            default: halt <= halt;
          endcase
        end
      end
      ST_RT1: nbp <= sx(ram_rdata);
      ST_RT2: npc <= sx(ram_rdata);
      ST_O1:  y_w <= ram_rdata;
      ST_O2:  x_w <= ram_rdata;
      ST_EX: begin
        waddr[0] <= sp_p1[ADDR_W-1:0];
        wcnt     <= 2'd1;
        nsp      <= ext_t'(sp_p1);
        if (m_w == OPR_DIV) begin
          wval[0] <= '0;
          if (y_w == 0) begin
            err <= ERR_DIVZ;
          end
        end else begin
          wval[0] <= alu_r;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          wval[0] <= div_q;
        end
      end
      ST_J1: begin
        if (ram_rdata == 0) begin
          npc <= sx(m_w);
        end
        nsp <= ext_t'(sp_p1);
      end
      ST_S1: begin
        outv    <= 1'b1;
        out_val <= ram_rdata;
        nsp     <= ext_t'(sp_p1);
      end
      ST_WALK: begin
        if (left != '0 && !cur_ok) begin
          fault <= 1'b1;
        end
      end
      ST_WALK_C: begin
        cur  <= ram_rdata;
        left <= left - DATA_W'(1);
        if (steps < SP_W'(MEM_DEPTH)) begin
          steps <= steps + SP_W'(1);
        end
        anchor   <= ram_rdata[ADDR_W-1:0];
        cyc_node <= ram_rdata[ADDR_W-1:0];
        cyc_len  <= '0;
      end
      ST_CYC_C: begin
        cyc_node <= ram_rdata[ADDR_W-1:0];
        cyc_len  <= cyc_len + SP_W'(1);
      end
      ST_MODW: begin
        if (div_done) begin
          left <= DATA_W'(div_r);
        end
      end
      ST_AW: begin
        if (aw_fault) begin
          fault <= 1'b1;
        end else begin
          sto_addr <= mem_a[ADDR_W-1:0];
          if (op_w == OP_CAL) begin
            waddr[0] <= sp_m1[ADDR_W-1:0];
            wval[0]  <= cur;
            waddr[1] <= ADDR_W'(sp - SP_W'(2));
            wval[1]  <= word_t'(bp);
            waddr[2] <= ADDR_W'(sp - SP_W'(3));
            wval[2]  <= word_t'(npc);
            wcnt     <= 2'd3;
            nbp      <= ext_t'(sp_m1);
            npc      <= sx(m_w);
          end
        end
      end
      ST_L1: begin
        waddr[0] <= sp_m1[ADDR_W-1:0];
        wval[0]  <= ram_rdata;
        wcnt     <= 2'd1;
        nsp      <= ext_t'(sp_m1);
      end
      ST_T1: begin
        waddr[0] <= sto_addr;
        wval[0]  <= ram_rdata;
        wcnt     <= 2'd1;
        nsp      <= ext_t'(sp_p1);
      end
      ST_FIN: begin
        if (fault || range_bad) begin
          err     <= ERR_ADDR;
          outv    <= 1'b0;
          out_val <= '0;
          inp     <= 1'b0;
        end
      end
      ST_COMMIT: begin
        if (widx != wcnt) begin
          widx <= widx + 2'd1;
        end
      end
      default: halt <= halt;
    endcase
  end

  pl0_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pl0_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

endmodule

/* design/pl0_ram.sv */
// generic single write, single read port ram with registered read data
// no dependencies

module pl0_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/pl0_div.sv */
// shared restoring divider, one quotient bit per cycle, signed or unsigned
// depends on pl0_pkg

module pl0_div import pl0_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  input  word_t    dividend,
  input  word_t    divisor,
  output logic     done,
  output word_t    quotient,
  output word_t    remainder
);

  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dmag;
  logic [CNT_W-1:0]  cnt;
  logic              qneg;
  logic              busy;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  assign shifted   = {rem, quo[DATA_W-1]};
  assign trial     = shifted - {1'b0, dmag};
  assign done      = busy && (cnt == '0);
  assign quotient  = qneg ? -word_t'(quo) : word_t'(quo);
  assign remainder = word_t'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= (req.sgn && dividend[DATA_W-1]) ? -dividend : dividend;
      dmag <= (req.sgn && divisor[DATA_W-1]) ? -divisor : divisor;
      rem  <= '0;
      cnt  <= CNT_W'(DIV_STEPS);
      qneg <= req.sgn && (dividend[DATA_W-1] ^ divisor[DATA_W-1]);
    end else if (busy && cnt != '0) begin
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

/* design/pl0_checker.sv */
// port-level checks on the stack machine core, bound to the top level
// depends on pl0_pkg and pl0_stack_machine_core_unit

module pl0_checker import pl0_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // an address error always leaves the machine stopped
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[O_ERR_H:O_ERR_L] == ERR_ADDR) |-> m_tdata[O_HALT])
    else $error("address error without halted");

  // write and read never come from the same item
  a_one_sys: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[O_OUTV] && m_tdata[O_INP]))
    else $error("out_valid and input_taken together");

  // no printed value without out_valid
  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[O_OUTV] |-> (m_tdata[O_VAL_H:O_VAL_L] == '0))
    else $error("out_value set without out_valid");

  // the block works on one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a second item at once");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed under stall");

endmodule

bind pl0_stack_machine_core_unit pl0_checker u_pl0_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
